### design/lsbm_pkg.sv
// Package with the transfer types, codes and internal structs of the bank mapper.
`timescale 1ns / 1ps

package lsbm_pkg;

  // Access kinds carried by the opcode field.
  localparam logic [1:0] OP_CPU_RD = 2'd0;
  localparam logic [1:0] OP_CPU_WR = 2'd1;
  localparam logic [1:0] OP_PPU_RD = 2'd2;
  localparam logic [1:0] OP_PPU_WR = 2'd3;

  // Memory targets.
  localparam logic [2:0] TGT_NONE   = 3'd0;
  localparam logic [2:0] TGT_SAVE   = 3'd1;
  localparam logic [2:0] TGT_PROG   = 3'd2;
  localparam logic [2:0] TGT_PATROM = 3'd3;
  localparam logic [2:0] TGT_PATRAM = 3'd4;
  localparam logic [2:0] TGT_CIRAM  = 3'd5;

  // Pattern memory kinds held in the configuration register.
  localparam logic [1:0] PSRC_ROM = 2'd0;
  localparam logic [1:0] PSRC_RAM = 2'd1;

  // Fixed program banks for the upper three windows.
  localparam logic [3:0] BANK_A000 = 4'hd;
  localparam logic [3:0] BANK_C000 = 4'he;
  localparam logic [3:0] BANK_E000 = 4'hf;

  // Register select on CPU address bits 15 to 12.
  localparam logic [3:0] REG_PROG  = 4'ha;
  localparam logic [3:0] REG_PAT0  = 4'hb;
  localparam logic [3:0] REG_PAT1  = 4'hc;
  localparam logic [3:0] REG_PAT2  = 4'hd;
  localparam logic [3:0] REG_PAT3  = 4'he;
  localparam logic [3:0] REG_MIRR  = 4'hf;

  // Latch trigger tiles: PPU address bits 11 to 3.
  localparam logic [8:0] TILE_CLR = 9'h1fb;
  localparam logic [8:0] TILE_SET = 9'h1fd;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [16:0] mem_address;
    logic        write_enable;
    logic [7:0]  data_out;
  } out_item_t;

  // Current bank state seen by the decoder.
  typedef struct packed {
    logic [3:0]      prog_bank;
    logic [3:0][4:0] pattern_bank;
    logic            mirror_select;
    logic [1:0]      half_latch;
  } bank_state_t;

  // Register loads requested by one access.
  typedef struct packed {
    logic       prog_load;
    logic [3:0] pat_load;
    logic       mirror_load;
    logic [4:0] load_data;
    logic [1:0] latch_set;
    logic [1:0] latch_clr;
  } bank_update_t;

endpackage

### design/lsbm_decode.sv
// Combinational access decoder: maps one bus access and requests register updates.
`timescale 1ns / 1ps

module lsbm_decode (
  input  lsbm_pkg::in_item_t     item,
  input  lsbm_pkg::bank_state_t  state,
  input  logic [1:0]             pattern_source,
  output lsbm_pkg::out_item_t    result,
  output lsbm_pkg::bank_update_t update
);

  logic [15:0] a;
  logic        is_wr;
  logic        is_ppu;
  logic        half;
  logic [4:0]  pat_bank;
  logic [3:0]  cpu_bank;
  logic        mirror_bit;

  assign a      = item.bus_address;
  assign is_ppu = item.opcode[1];
  assign is_wr  = item.opcode[0];
  assign half   = a[12];

  // Pattern bank is chosen from the latch value before this fetch updates it.
  assign pat_bank   = state.pattern_bank[{half, state.half_latch[half]}];
  assign mirror_bit = state.mirror_select ? a[11] : a[10];

  // Program bank for the CPU window.
  always_comb begin
    case (a[14:13])
      2'd0:    cpu_bank = state.prog_bank;
      2'd1:    cpu_bank = lsbm_pkg::BANK_A000;
      2'd2:    cpu_bank = lsbm_pkg::BANK_C000;
      default: cpu_bank = lsbm_pkg::BANK_E000;
    endcase
  end

  // Result mapping and register loads.
  always_comb begin
    result.target       = lsbm_pkg::TGT_NONE;
    result.mem_address  = 17'd0;
    result.write_enable = 1'b0;
    result.data_out     = item.bus_data;
    update              = '0;
    update.load_data    = item.bus_data[4:0];

    if (!is_ppu) begin
      if (a[15:13] == 3'b011) begin
        // Save RAM window.
        result.target       = lsbm_pkg::TGT_SAVE;
        result.mem_address  = {4'd0, a[12:0]};
        result.write_enable = is_wr;
      end else if (a[15]) begin
        if (!is_wr) begin
          result.target      = lsbm_pkg::TGT_PROG;
          result.mem_address = {cpu_bank, a[12:0]};
        end else begin
          unique case (a[15:12])
            lsbm_pkg::REG_PROG: update.prog_load   = 1'b1;
            lsbm_pkg::REG_PAT0: update.pat_load[0] = 1'b1;
            lsbm_pkg::REG_PAT1: update.pat_load[1] = 1'b1;
            lsbm_pkg::REG_PAT2: update.pat_load[2] = 1'b1;
            lsbm_pkg::REG_PAT3: update.pat_load[3] = 1'b1;
            lsbm_pkg::REG_MIRR: update.mirror_load = 1'b1;
            default: ;
          endcase
        end
      end
    end else if (a[13]) begin
      // Nametable space goes to console RAM.
      result.target       = lsbm_pkg::TGT_CIRAM;
      result.mem_address  = {6'd0, mirror_bit, a[9:0]};
      result.write_enable = is_wr;
    end else begin
      // Pattern table fetch, with latch triggers on the marker tiles.
      update.latch_clr[half] = (a[11:3] == lsbm_pkg::TILE_CLR);
      update.latch_set[half] = (a[11:3] == lsbm_pkg::TILE_SET);
      if (pattern_source == lsbm_pkg::PSRC_RAM) begin
        result.target       = lsbm_pkg::TGT_PATRAM;
        result.mem_address  = {pat_bank, a[11:0]};
        result.write_enable = is_wr;
      end else if (pattern_source == lsbm_pkg::PSRC_ROM && !is_wr) begin
        result.target      = lsbm_pkg::TGT_PATROM;
        result.mem_address = {pat_bank, a[11:0]};
      end
    end
  end

endmodule

### design/lsbm_state.sv
// Bank, mirroring and latch registers, updated by each decoded access.
`timescale 1ns / 1ps

module lsbm_state (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  lsbm_pkg::bank_update_t update,
  output lsbm_pkg::bank_state_t  state
);

  lsbm_pkg::bank_state_t state_r;
  lsbm_pkg::bank_state_t state_nxt;

  // Apply the requested loads.
  always_comb begin
    state_nxt = state_r;
    if (en) begin
      if (update.prog_load) begin
        state_nxt.prog_bank = update.load_data[3:0];
      end
      for (int i = 0; i < 4; i++) begin
        if (update.pat_load[i]) begin
          state_nxt.pattern_bank[i] = update.load_data;
        end
      end
      if (update.mirror_load) begin
        state_nxt.mirror_select = update.load_data[0];
      end
      for (int h = 0; h < 2; h++) begin
        if (update.latch_clr[h]) begin
          state_nxt.half_latch[h] = 1'b0;
        end else if (update.latch_set[h]) begin
          state_nxt.half_latch[h] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

### design/latch_switched_bank_mapper.sv
// Top level of the latch-switched bank mapper: transfer registers, decoder and bank state.
`timescale 1ns / 1ps

// Latch-switched bank mapper. Each accepted bus access (CPU or PPU, read or
// write) yields exactly one result: target memory, mapped address, write
// strobe and data byte. The block accepts one transfer every cycle while
// in_stall is low. An access passes the input register, the combinational
// decoder and the result register, in that order. The input stalls only
// while its register is full and the result register holds a stalled result.
// Bank registers and pattern latches change as the access passes the decoder,
// so the next access already sees them. The user must write pattern_source
// through cfg_we/cfg_wdata only while the block is idle; the block itself
// does not enforce this.
module latch_switched_bank_mapper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsbm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lsbm_pkg::out_item_t out_item
);

  logic [1:0]             pattern_source_r;
  logic                   in_valid_r;
  lsbm_pkg::in_item_t     in_item_r;
  logic                   out_valid_r;
  lsbm_pkg::out_item_t    out_item_r;
  logic                   out_free;
  logic                   advance;
  lsbm_pkg::out_item_t    result;
  lsbm_pkg::bank_update_t update;
  lsbm_pkg::bank_state_t  state;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_source_r <= 2'd0;
    end else if (cfg_we) begin
      pattern_source_r <= cfg_wdata;
    end
  end

  // Pipeline flow: the result register frees when empty or when its transfer completes.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  lsbm_decode u_decode (
    .item           (in_item_r),
    .state          (state),
    .pattern_source (pattern_source_r),
    .result         (result),
    .update         (update)
  );

  lsbm_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .update (update),
    .state  (state)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // The input side only stalls while a finished result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // An open-bus result never carries an address or a write strobe.
  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.target == lsbm_pkg::TGT_NONE) |->
      (out_item.mem_address == 17'd0 && !out_item.write_enable))
    else $error("open-bus result with address or write strobe");

  // Only writable targets are strobed.
  a_we_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.write_enable) |->
      (out_item.target == lsbm_pkg::TGT_SAVE ||
       out_item.target == lsbm_pkg::TGT_PATRAM ||
       out_item.target == lsbm_pkg::TGT_CIRAM))
    else $error("write strobe on a read-only target");

  // A stalled result register keeps its item through the next edge.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("held result changed");
`endif

endmodule

### verif/mapper_checker.sv
// Checker for the bank mapper: tracks bank state, predicts each mapped access and compares results.
`timescale 1ns / 1ps

module mapper_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lsbm_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lsbm_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  outstanding
);

  // Shadow copy of the mapper registers and pattern latches.
  logic [3:0] prg_bank;
  logic [4:0] chr_bank [4];
  logic       mirror_a11;
  logic [1:0] chr_latch;
  logic [1:0] chr_kind;

  // Mapped accesses still waiting for their result transfer.
  lsbm_pkg::out_item_t  mapped_q [$];
  lsbm_pkg::out_item_t  want;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Maps one bus access and applies its side effects on the shadow state.
  task automatic map_access(input lsbm_pkg::in_item_t acc, output lsbm_pkg::out_item_t res);
    logic [13:0] pa;
    logic        half;
    logic        wr;
    logic [4:0]  cbank;
    logic [3:0]  pbank;
    res.target       = lsbm_pkg::TGT_NONE;
    res.mem_address  = '0;
    res.write_enable = 1'b0;
    res.data_out     = acc.bus_data;
    case (acc.opcode)
      lsbm_pkg::OP_CPU_RD: begin
        if (acc.bus_address >= 16'h8000) begin
          case (acc.bus_address[15:13])
            3'b100:  pbank = prg_bank;
            3'b101:  pbank = lsbm_pkg::BANK_A000;
            3'b110:  pbank = lsbm_pkg::BANK_C000;
            default: pbank = lsbm_pkg::BANK_E000;
          endcase
          res.target      = lsbm_pkg::TGT_PROG;
          res.mem_address = {pbank, acc.bus_address[12:0]};
        end else if (acc.bus_address >= 16'h6000) begin
          res.target      = lsbm_pkg::TGT_SAVE;
          res.mem_address = {4'b0, acc.bus_address[12:0]};
        end
      end
      lsbm_pkg::OP_CPU_WR: begin
        if (acc.bus_address >= 16'h8000) begin
          // Register writes produce no memory access.
          case (acc.bus_address[15:12])
            lsbm_pkg::REG_PROG: prg_bank    = acc.bus_data[3:0];
            lsbm_pkg::REG_PAT0: chr_bank[0] = acc.bus_data[4:0];
            lsbm_pkg::REG_PAT1: chr_bank[1] = acc.bus_data[4:0];
            lsbm_pkg::REG_PAT2: chr_bank[2] = acc.bus_data[4:0];
            lsbm_pkg::REG_PAT3: chr_bank[3] = acc.bus_data[4:0];
            lsbm_pkg::REG_MIRR: mirror_a11  = acc.bus_data[0];
            default: ;
          endcase
        end else if (acc.bus_address >= 16'h6000) begin
          res.target       = lsbm_pkg::TGT_SAVE;
          res.mem_address  = {4'b0, acc.bus_address[12:0]};
          res.write_enable = 1'b1;
        end
      end
      default: begin
        pa = acc.bus_address[13:0];
        wr = (acc.opcode == lsbm_pkg::OP_PPU_WR);
        if (pa[13]) begin
          // Nametable space goes to console RAM.
          res.target       = lsbm_pkg::TGT_CIRAM;
          res.mem_address  = {6'b0, (mirror_a11 ? pa[11] : pa[10]), pa[9:0]};
          res.write_enable = wr;
        end else begin
          // The bank is picked before the fetch moves the latch.
          half  = pa[12];
          cbank = chr_bank[{half, chr_latch[half]}];
          if (pa[11:3] == lsbm_pkg::TILE_CLR) chr_latch[half] = 1'b0;
          if (pa[11:3] == lsbm_pkg::TILE_SET) chr_latch[half] = 1'b1;
          if (chr_kind == lsbm_pkg::PSRC_RAM) begin
            res.target       = lsbm_pkg::TGT_PATRAM;
            res.mem_address  = {cbank, pa[11:0]};
            res.write_enable = wr;
          end else if (chr_kind == lsbm_pkg::PSRC_ROM && !wr) begin
            res.target      = lsbm_pkg::TGT_PATROM;
            res.mem_address = {cbank, pa[11:0]};
          end
        end
      end
    endcase
  endtask

  // Compare result transfers first, then predict the input transfer of the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      prg_bank   = '0;
      chr_bank   = '{default: '0};
      mirror_a11 = 1'b0;
      chr_latch  = '0;
      chr_kind   = lsbm_pkg::PSRC_ROM;
      fail_count = 0;
      mapped_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (mapped_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected, target %0d addr %0h",
                                    out_item.target, out_item.mem_address));
        end else begin
          want = mapped_q.pop_front();
          if (out_item.target !== want.target)
            report_mismatch($sformatf("target got %0d expected %0d",
                                      out_item.target, want.target));
          if (out_item.mem_address !== want.mem_address)
            report_mismatch($sformatf("mem_address got %0h expected %0h",
                                      out_item.mem_address, want.mem_address));
          if (out_item.write_enable !== want.write_enable)
            report_mismatch($sformatf("write_enable got %0b expected %0b",
                                      out_item.write_enable, want.write_enable));
          if (out_item.data_out !== want.data_out)
            report_mismatch($sformatf("data_out got %0h expected %0h",
                                      out_item.data_out, want.data_out));
        end
      end
      if (cfg_we) chr_kind = cfg_wdata;
      if (in_valid && !in_stall) begin
        map_access(in_item, want);
        mapped_q.push_back(want);
      end
    end
    outstanding = mapped_q.size();
  end

endmodule

### verif/testbench.sv
// Testbench top for the bank mapper: clock, reset, access stimulus, configuration and verdict.
`timescale 1ns / 1ps

module testbench;

  // Pattern memory kinds without a package name: absent, and the unused code.
  localparam logic [1:0] PSRC_NONE   = 2'd2;
  localparam logic [1:0] PSRC_UNUSED = 2'd3;
  localparam int         PHASE_ITEMS = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  lsbm_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lsbm_pkg::out_item_t out_item;
  int                  fail_count;
  int                  outstanding;
  bit                  in_idle_on = 1'b1;
  bit                  out_idle_on = 1'b1;

  latch_switched_bank_mapper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  mapper_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side stalls at random unless idling is switched off.
  always @(negedge clk) begin
    out_stall <= out_idle_on && ($urandom_range(0, 99) < 13);
  end

  function automatic lsbm_pkg::in_item_t access(input logic [1:0] op,
                                                input logic [15:0] addr,
                                                input logic [7:0] data);
    lsbm_pkg::in_item_t acc;
    acc.opcode      = op;
    acc.bus_address = addr;
    acc.bus_data    = data;
    return acc;
  endfunction

  // Random access, biased toward register writes and latch trigger tiles.
  function automatic lsbm_pkg::in_item_t random_access();
    lsbm_pkg::in_item_t acc;
    int                 sel;
    acc.opcode   = 2'($urandom_range(0, 3));
    acc.bus_data = 8'($urandom);
    sel          = $urandom_range(0, 99);
    if (acc.opcode == lsbm_pkg::OP_CPU_WR && sel < 40) begin
      acc.bus_address = {4'($urandom_range(lsbm_pkg::REG_PROG, lsbm_pkg::REG_MIRR)),
                         12'($urandom)};
    end else if (acc.opcode == lsbm_pkg::OP_PPU_RD || acc.opcode == lsbm_pkg::OP_PPU_WR) begin
      if (sel < 45)
        acc.bus_address = {2'($urandom), 1'b0, 1'($urandom),
                           (sel < 22) ? lsbm_pkg::TILE_CLR : lsbm_pkg::TILE_SET,
                           3'($urandom)};
      else if (sel < 75)
        acc.bus_address = {2'($urandom), 1'b0, 13'($urandom)};
      else
        acc.bus_address = 16'($urandom);
    end else begin
      acc.bus_address = 16'($urandom);
    end
    return acc;
  endfunction

  // Presents one access and returns at the edge where the transfer happens.
  task automatic send_access(input lsbm_pkg::in_item_t acc);
    @(negedge clk);
    while (in_idle_on && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= acc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending and waits until every mapped access has come back.
  task automatic settle_bus();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_pattern_source(input logic [1:0] kind);
    settle_bus();
    cfg_we    <= 1'b1;
    cfg_wdata <= kind;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [1:0] kind_seq [5];
    kind_seq[0] = lsbm_pkg::PSRC_RAM;
    kind_seq[1] = PSRC_NONE;
    kind_seq[2] = lsbm_pkg::PSRC_ROM;
    kind_seq[3] = PSRC_UNUSED;
    kind_seq[4] = lsbm_pkg::PSRC_RAM;

    // Synchronous reset.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    load_pattern_source(lsbm_pkg::PSRC_ROM);

    // Directed accesses: open bus, save RAM, ignored writes, every register,
    // every program window, latch switching and both mirroring modes.
    send_access(access(lsbm_pkg::OP_CPU_RD, 16'h0000, 8'hff));
    send_access(access(lsbm_pkg::OP_CPU_RD, 16'h5fff, 8'h00));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'h5fff, 8'h5a));
    send_access(access(lsbm_pkg::OP_CPU_RD, 16'h6000, 8'h12));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'h7fff, 8'ha5));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'h8000, 8'hff));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'h9fff, 8'h3c));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'ha000, 8'hff));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'hbfff, 8'h1f));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'hc000, 8'h15));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'hd123, 8'h0a));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'he000, 8'hff));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'hf000, 8'h01));
    send_access(access(lsbm_pkg::OP_CPU_RD, 16'h8000, 8'h00));
    send_access(access(lsbm_pkg::OP_CPU_RD, 16'ha000, 8'h00));
    send_access(access(lsbm_pkg::OP_CPU_RD, 16'hc123, 8'h00));
    send_access(access(lsbm_pkg::OP_CPU_RD, 16'hffff, 8'hff));
    send_access(access(lsbm_pkg::OP_PPU_RD, 16'h0fd8, 8'h00));
    send_access(access(lsbm_pkg::OP_PPU_RD, 16'h0fe8, 8'h00));
    send_access(access(lsbm_pkg::OP_PPU_RD, 16'h0000, 8'h00));
    send_access(access(lsbm_pkg::OP_PPU_RD, 16'h1fef, 8'h00));
    send_access(access(lsbm_pkg::OP_PPU_WR, 16'hdfdf, 8'h77));
    send_access(access(lsbm_pkg::OP_PPU_RD, 16'h1000, 8'h00));
    send_access(access(lsbm_pkg::OP_PPU_WR, 16'he7ff, 8'h81));
    send_access(access(lsbm_pkg::OP_CPU_WR, 16'hf000, 8'hfe));
    send_access(access(lsbm_pkg::OP_PPU_RD, 16'h2c00, 8'h00));

    // Random phases over every pattern memory kind, pattern RAM twice.
    for (int phase = 0; phase < 5; phase++) begin
      load_pattern_source(kind_seq[phase]);
      in_idle_on  = (phase != 2);
      out_idle_on = (phase != 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 0 && k == PHASE_ITEMS / 2) settle_bus();
        send_access(random_access());
      end
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;

    settle_bus();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
